// ----- hdl/blm_pkg.sv -----
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants of the battery level monitor
// Holds the window size, the datapath widths, the register map, the sequencer
// states and the nine-point Li-ion discharge curve.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Samples summed into one averaging window.
    localparam int AdcSamples = 16;

    // Field and register widths.
    localparam int AdcW  = 12;
    localparam int CfgW  = 16;
    localparam int MvW   = 16;
    localparam int PctW  = 7;
    localparam int CntW  = 8;

    // Datapath widths: window sum, scaled product and divider dividend.
    localparam int SumW  = 20;
    localparam int ProdW = SumW + CfgW;
    localparam int DivW  = ProdW + 1;
    localparam int DcntW = $clog2(DivW);
    localparam int McntW = $clog2(CfgW);

    // Register map, by word index.
    localparam logic [1:0] RegDivNum    = 2'd0;
    localparam logic [1:0] RegDivDen    = 2'd1;
    localparam logic [1:0] RegThreshold = 2'd2;

    // Register reset values.
    localparam logic [CfgW-1:0] DivNumReset    = 16'd2;
    localparam logic [CfgW-1:0] DivDenReset    = 16'd1;
    localparam logic [CfgW-1:0] ThresholdReset = 16'd2500;

    // Discharge curve: cell millivolts against charge percent.
    localparam int CurvePoints = 9;
    localparam logic [MvW-1:0] CurveMv [CurvePoints] = '{
        16'd3300, 16'd3500, 16'd3600, 16'd3700, 16'd3800,
        16'd3900, 16'd4000, 16'd4100, 16'd4200
    };
    localparam logic [PctW-1:0] CurvePct [CurvePoints] = '{
        7'd0, 7'd5, 7'd10, 7'd25, 7'd45, 7'd65, 7'd80, 7'd90, 7'd100
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        t_idle_st   = 3'd0,
        t_avg_st    = 3'd1,
        t_mul_st    = 3'd2,
        t_scale_st  = 3'd3,
        t_filt_st   = 3'd4,
        t_pct_st    = 3'd5,
        t_interp_st = 3'd6,
        t_out_st    = 3'd7
    } t_state;

endpackage

// ----- hdl/battery_level_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_level_monitor: voltage-curve battery fuel gauge
// Averages windows of ADC millivolt samples, scales them by a resistor divider
// ratio, smooths the cell voltage and interpolates a charge percent.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the s_axis channel, one 12-bit millivolt reading per word.
// A sample that does not close a window is summed as it is taken and the next
// word may follow straight away. The sample that closes a window of
// AdcSamples words starts the window processing, and s_axis_tready stays low
// until it is done: with the smoothed voltage inside the curve this takes
// three passes of the bit-serial divider, a shift-add multiply and the
// filter, percent and output steps; when the battery is absent or the voltage
// is off the curve the interpolation pass is skipped. The divider and the
// multiplier retire one bit per cycle.
// The result word (smoothed millivolts, charge percent, presence flag) is held
// in an output register on m_axis. While it waits for m_axis_tready the block
// keeps accepting samples; only a further window end waits for the register
// to empty, so a stalled receiver never loses a result.
// The APB port writes and reads the divider numerator, denominator and the
// presence threshold; it must be written only while the block is idle.
// Reset restores the register defaults, clears the window, the smoothed
// voltage and the output register.
// ----------------------------------------------------------------------------
module battery_level_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream; s_axis_tdata: [11:0] adc_millivolts, [15:12] zero.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Result stream; m_axis_tdata: [15:0] smoothed_millivolts,
    // [22:16] charge_percent, [23] present.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Registers.
    blm_pkg::t_state                     r_state, n_state;
    logic [blm_pkg::CfgW-1:0]            r_num, r_den, r_thr;
    logic [blm_pkg::SumW-1:0]            r_sum, n_sum;
    logic [blm_pkg::CntW-1:0]            r_cnt, n_cnt;
    logic [blm_pkg::SumW-1:0]            r_avg, n_avg;
    logic [blm_pkg::ProdW-1:0]           r_prod, n_prod;
    logic [blm_pkg::McntW-1:0]           r_mcnt, n_mcnt;
    logic [blm_pkg::DivW-1:0]            r_quo, n_quo;
    logic [blm_pkg::CfgW-1:0]            r_rem, n_rem;
    logic [blm_pkg::CfgW-1:0]            r_dsr, n_dsr;
    logic [blm_pkg::DcntW-1:0]           r_dcnt, n_dcnt;
    logic [blm_pkg::MvW-1:0]             r_scaled, n_scaled;
    logic [blm_pkg::MvW-1:0]             r_filt, n_filt;
    logic                                r_seen, n_seen;
    logic [blm_pkg::PctW-1:0]            r_pct, n_pct;
    logic                                r_out_valid, n_out_valid;
    logic [23:0]                         r_out_data, n_out_data;

    // Divider step signals.
    logic [blm_pkg::CfgW:0]              rem_sh;
    logic                                div_ge;
    logic [blm_pkg::CfgW-1:0]            step_rem;
    logic [blm_pkg::DivW-1:0]            step_quo;
    logic                                div_last;

    // Multiplier step signals.
    logic [blm_pkg::SumW:0]              mul_sum;

    // Filter and curve signals.
    logic [blm_pkg::MvW+1:0]             filt_acc;
    logic [3:0]                          seg;
    logic                                seg_found;
    logic [blm_pkg::MvW-1:0]             seg_diff;
    logic [11:0]                         seg_prod;
    logic [blm_pkg::PctW-1:0]            seg_dp;

    logic                                cfg_wr;

    // Handshakes.
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (r_state == blm_pkg::t_idle_st);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            blm_pkg::RegDivNum:    prdata = {16'd0, r_num};
            blm_pkg::RegDivDen:    prdata = {16'd0, r_den};
            blm_pkg::RegThreshold: prdata = {16'd0, r_thr};
            default:               prdata = 32'd0;
        endcase
    end

    // One restoring division step: one quotient bit per cycle.
    assign rem_sh   = {r_rem, r_quo[blm_pkg::DivW-1]};
    assign div_ge   = (rem_sh >= {1'b0, r_dsr});
    assign step_rem = div_ge ? blm_pkg::CfgW'(rem_sh - {1'b0, r_dsr})
                             : rem_sh[blm_pkg::CfgW-1:0];
    assign step_quo = {r_quo[blm_pkg::DivW-2:0], div_ge};
    assign div_last = (r_dcnt == blm_pkg::DcntW'(blm_pkg::DivW - 1));

    // One shift-add multiply step: one multiplier bit per cycle.
    assign mul_sum = {1'b0, r_prod[blm_pkg::ProdW-1:blm_pkg::CfgW]}
                   + (r_prod[0] ? {1'b0, r_avg} : '0);

    // Smoothing: 3*old + new + 2, divided by four later.
    assign filt_acc = ({2'b0, r_filt} << 1) + {2'b0, r_filt} + {2'b0, r_scaled} + 18'd2;

    // Curve segment: first point at or above the smoothed voltage.
    always_comb begin
        seg       = 4'd1;
        seg_found = 1'b0;
        for (int i = 1; i < blm_pkg::CurvePoints; i++) begin
            if (!seg_found && (r_filt <= blm_pkg::CurveMv[i])) begin
                seg       = 4'(i);
                seg_found = 1'b1;
            end
        end
    end

    assign seg_diff = r_filt - blm_pkg::CurveMv[seg - 4'd1];
    assign seg_dp   = blm_pkg::CurvePct[seg] - blm_pkg::CurvePct[seg - 4'd1];
    assign seg_prod = 12'(seg_diff[7:0] * seg_dp[4:0]);

    // Sequencer: next state and datapath loads.
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_avg       = r_avg;
        n_prod      = r_prod;
        n_mcnt      = r_mcnt;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_dcnt      = r_dcnt;
        n_scaled    = r_scaled;
        n_filt      = r_filt;
        n_seen      = r_seen;
        n_pct       = r_pct;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // The receiver empties the output register.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            blm_pkg::t_idle_st: begin
                if (s_axis_tvalid) begin
                    n_sum = r_sum + blm_pkg::SumW'(s_axis_tdata[blm_pkg::AdcW-1:0]);
                    if (r_cnt == blm_pkg::CntW'(blm_pkg::AdcSamples - 1)) begin
                        // Window complete: divide the sum by the window size.
                        n_quo   = blm_pkg::DivW'(n_sum);
                        n_rem   = '0;
                        n_dsr   = blm_pkg::CfgW'(blm_pkg::AdcSamples);
                        n_dcnt  = '0;
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_state = blm_pkg::t_avg_st;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            blm_pkg::t_avg_st: begin
                n_quo  = step_quo;
                n_rem  = step_rem;
                n_dcnt = r_dcnt + 1'b1;
                if (div_last) begin
                    n_avg   = step_quo[blm_pkg::SumW-1:0];
                    n_prod  = {{blm_pkg::SumW{1'b0}}, r_num};
                    n_mcnt  = '0;
                    n_state = blm_pkg::t_mul_st;
                end
            end
            blm_pkg::t_mul_st: begin
                n_prod = {mul_sum, r_prod[blm_pkg::CfgW-1:1]};
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == blm_pkg::McntW'(blm_pkg::CfgW - 1)) begin
                    // Add half the denominator for rounding, then divide.
                    n_quo   = {1'b0, n_prod} + blm_pkg::DivW'(r_den[blm_pkg::CfgW-1:1]);
                    n_rem   = '0;
                    n_dsr   = r_den;
                    n_dcnt  = '0;
                    n_state = blm_pkg::t_scale_st;
                end
            end
            blm_pkg::t_scale_st: begin
                n_quo  = step_quo;
                n_rem  = step_rem;
                n_dcnt = r_dcnt + 1'b1;
                if (div_last) begin
                    // Saturate at full scale; a zero denominator lands here too.
                    if (|step_quo[blm_pkg::DivW-1:blm_pkg::MvW]) begin
                        n_scaled = '1;
                    end else begin
                        n_scaled = step_quo[blm_pkg::MvW-1:0];
                    end
                    n_state = blm_pkg::t_filt_st;
                end
            end
            blm_pkg::t_filt_st: begin
                n_seen = (r_scaled >= r_thr);
                priority if (r_scaled < r_thr) begin
                    n_filt = '0;
                end else if (r_filt == '0) begin
                    n_filt = r_scaled;
                end else begin
                    n_filt = filt_acc[blm_pkg::MvW+1:2];
                end
                n_state = blm_pkg::t_pct_st;
            end
            blm_pkg::t_pct_st: begin
                priority if (!r_seen || r_filt <= blm_pkg::CurveMv[0]) begin
                    n_pct   = '0;
                    n_state = blm_pkg::t_out_st;
                end else if (r_filt >= blm_pkg::CurveMv[blm_pkg::CurvePoints-1]) begin
                    n_pct   = blm_pkg::CurvePct[blm_pkg::CurvePoints-1];
                    n_state = blm_pkg::t_out_st;
                end else begin
                    // Interpolate inside the segment through the divider.
                    n_pct   = blm_pkg::CurvePct[seg - 4'd1];
                    n_quo   = blm_pkg::DivW'(seg_prod);
                    n_rem   = '0;
                    n_dsr   = blm_pkg::CurveMv[seg] - blm_pkg::CurveMv[seg - 4'd1];
                    n_dcnt  = '0;
                    n_state = blm_pkg::t_interp_st;
                end
            end
            blm_pkg::t_interp_st: begin
                n_quo  = step_quo;
                n_rem  = step_rem;
                n_dcnt = r_dcnt + 1'b1;
                if (div_last) begin
                    n_pct   = r_pct + step_quo[blm_pkg::PctW-1:0];
                    n_state = blm_pkg::t_out_st;
                end
            end
            blm_pkg::t_out_st: begin
                // Wait until the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_seen, r_pct, r_filt};
                    n_state     = blm_pkg::t_idle_st;
                end
            end
            default: begin
                n_state = blm_pkg::t_idle_st;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blm_pkg::t_idle_st;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_filt      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_num       <= blm_pkg::DivNumReset;
            r_den       <= blm_pkg::DivDenReset;
            r_thr       <= blm_pkg::ThresholdReset;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_filt      <= n_filt;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    blm_pkg::RegDivNum:    r_num <= pwdata[blm_pkg::CfgW-1:0];
                    blm_pkg::RegDivDen:    r_den <= pwdata[blm_pkg::CfgW-1:0];
                    blm_pkg::RegThreshold: r_thr <= pwdata[blm_pkg::CfgW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_avg      <= n_avg;
        r_prod     <= n_prod;
        r_mcnt     <= n_mcnt;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_dsr      <= n_dsr;
        r_dcnt     <= n_dcnt;
        r_scaled   <= n_scaled;
        r_pct      <= n_pct;
        r_out_data <= n_out_data;
    end

endmodule

// ----- sim/tb_battery_level_monitor.sv -----
// ----------------------------------------------------------------------------
// tb_battery_level_monitor: self-checking testbench of the battery level monitor
// Streams ADC millivolt windows into the gauge under a range of divider and
// threshold settings, predicts every result word in a scoreboard of its own
// and compares smoothed millivolts, charge percent and presence field by
// field. Both stream sides idle and stall at random, the receiver holds off
// once for a long stretch, and the register file is read back after writes.
// ----------------------------------------------------------------------------
module tb_battery_level_monitor;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [1:0] RegSpare = 2'd3;

    localparam int unsigned SettleCycles   = 200;
    localparam int unsigned LongHoldCycles = 700;
    localparam int unsigned RandomPhases   = 5;
    localparam int unsigned PhaseWindows   = 6;

    // Window levels for the directed part under the reset settings: silence,
    // full scale, the bottom and top of the curve and points in between.
    localparam int unsigned DirectedLevels [11] = '{
        0, 4095, 0, 1600, 1650, 0, 2100, 0, 1750, 1825, 1912
    };

    typedef enum {
        WinConst,
        WinNoisy,
        WinAlternate,
        WinRandom
    } t_window_kind;

    // Result word as it sits on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic                     present;
        logic [blm_pkg::PctW-1:0] pct;
        logic [blm_pkg::MvW-1:0]  mv;
    } t_gauge_word;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the gauge that turns accepted sample words
    // into expected result words and checks the words that come out.
    // ------------------------------------------------------------------------
    class t_gauge_scoreboard;
        int unsigned div_num;
        int unsigned div_den;
        int unsigned threshold;
        int unsigned window_sum;
        int unsigned window_count;
        int unsigned smoothed_mv;
        t_gauge_word expected_words [$];
        int unsigned mismatches;
        int unsigned words_checked;

        function new();
            div_num       = 32'(blm_pkg::DivNumReset);
            div_den       = 32'(blm_pkg::DivDenReset);
            threshold     = 32'(blm_pkg::ThresholdReset);
            window_sum    = 0;
            window_count  = 0;
            smoothed_mv   = 0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void report(string what, longint unsigned exp_val,
                             longint unsigned act_val);
            mismatches++;
            if (mismatches <= 10) begin
                $display("At %0t: %s mismatch, expected %0d, got %0d",
                         $time, what, exp_val, act_val);
            end
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                blm_pkg::RegDivNum:    div_num = 32'(value);
                blm_pkg::RegDivDen:    div_den = 32'(value);
                blm_pkg::RegThreshold: threshold = 32'(value);
                default: ;
            endcase
        endfunction

        function int unsigned register_value(logic [1:0] idx);
            case (idx)
                blm_pkg::RegDivNum:    return div_num;
                blm_pkg::RegDivDen:    return div_den;
                blm_pkg::RegThreshold: return threshold;
                default:               return 0;
            endcase
        endfunction

        function void check_register(logic [1:0] idx, logic [31:0] rdata);
            if (rdata != register_value(idx)) begin
                report("register read", register_value(idx), rdata);
            end
        endfunction

        // Linear interpolation over the discharge curve, truncated.
        function int unsigned charge_from_mv(int unsigned mv);
            int unsigned k;
            if (mv <= blm_pkg::CurveMv[0]) return 32'(blm_pkg::CurvePct[0]);
            if (mv >= blm_pkg::CurveMv[blm_pkg::CurvePoints-1]) begin
                return 32'(blm_pkg::CurvePct[blm_pkg::CurvePoints-1]);
            end
            for (k = 1; k < blm_pkg::CurvePoints; k++) begin
                if (mv <= blm_pkg::CurveMv[k]) begin
                    return int'(blm_pkg::CurvePct[k-1]) +
                           (mv - blm_pkg::CurveMv[k-1]) *
                           (int'(blm_pkg::CurvePct[k]) - int'(blm_pkg::CurvePct[k-1])) /
                           (int'(blm_pkg::CurveMv[k]) - int'(blm_pkg::CurveMv[k-1]));
                end
            end
            return 0;
        endfunction

        // Adds one sample word; the word that closes a window yields a result.
        function void note_sample(logic [blm_pkg::AdcW-1:0] mv);
            int unsigned     avg;
            longint unsigned scaled;
            logic            present;
            t_gauge_word     word;
            window_sum = (window_sum + mv) & 32'hF_FFFF;
            window_count++;
            if (window_count < blm_pkg::AdcSamples) return;
            avg          = window_sum / blm_pkg::AdcSamples;
            window_sum   = 0;
            window_count = 0;

            // Divider scaling with rounding; a zero denominator saturates.
            if (div_den == 0) begin
                scaled = 65535;
            end else begin
                scaled = (longint'(avg) * div_num + div_den / 2) / div_den;
                if (scaled > 65535) scaled = 65535;
            end

            // Presence and smoothing: cleared when absent, loaded from zero.
            present = (scaled >= threshold);
            if (!present) begin
                smoothed_mv = 0;
            end else if (smoothed_mv == 0) begin
                smoothed_mv = 32'(scaled);
            end else begin
                smoothed_mv = 32'((smoothed_mv * 3 + scaled + 2) / 4) & 32'hFFFF;
            end

            word.present = present;
            word.pct     = present ? blm_pkg::PctW'(charge_from_mv(smoothed_mv)) : '0;
            word.mv      = blm_pkg::MvW'(smoothed_mv);
            expected_words.push_back(word);
        endfunction

        function void check_result(logic [23:0] data);
            t_gauge_word got;
            t_gauge_word want;
            got = data;
            words_checked++;
            if (expected_words.size() == 0) begin
                report("unexpected result word", 0, data);
                return;
            end
            want = expected_words.pop_front();
            if (got.mv != want.mv) report("smoothed_millivolts", want.mv, got.mv);
            if (got.pct != want.pct) report("charge_percent", want.pct, got.pct);
            if (got.present != want.present) begin
                report("present", want.present, got.present);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_gauge_scoreboard sb;
    bit                tx_burst;
    bit                long_hold_due;
    int unsigned       sample_total;
    int unsigned       window_total;
    int unsigned       setting_total;

    always #2 i_clk = ~i_clk;

    battery_level_monitor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Register access over the configuration port.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Bits above the register width must be dropped by the block.
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_register(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.check_register(idx, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sample stream driving.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [blm_pkg::AdcW-1:0] mv,
                               input int unsigned gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, mv};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(mv);
        sample_total++;
    endtask

    task automatic send_window(input t_window_kind kind, input int unsigned level);
        int unsigned k;
        int          v;
        for (k = 0; k < blm_pkg::AdcSamples; k++) begin
            case (kind)
                WinConst:     v = level;
                WinNoisy:     v = int'(level) + int'($urandom_range(0, 40)) - 20;
                WinAlternate: v = k[0] ? 12'h555 : 12'hAAA;
                default:      v = $urandom_range(0, 4095);
            endcase
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            send_sample(v[blm_pkg::AdcW-1:0], tx_burst ? 0 : $urandom_range(0, 9));
        end
        window_total++;
    endtask

    // Mostly windows that settle on the discharge curve for the present
    // divider, the rest raw noise or a flat random level.
    task automatic send_random_window();
        int unsigned pick;
        int unsigned target;
        int unsigned level;
        pick   = $urandom_range(0, 9);
        target = $urandom_range(3150, 4350);
        if (sb.div_num == 0) begin
            level = $urandom_range(0, 4095);
        end else begin
            level = 32'((longint'(target) * sb.div_den) / sb.div_num);
            if (level > 4095) level = 4095;
        end
        tx_burst = ($urandom_range(0, 3) == 0);
        if (pick < 6) send_window(WinNoisy, level);
        else if (pick < 8) send_window(WinRandom, 0);
        else send_window(WinConst, $urandom_range(0, 4095));
    endtask

    // Waits until every expected word has arrived and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] num, input logic [15:0] den,
                             input logic [15:0] thr);
        wait_idle();
        write_register(blm_pkg::RegDivNum, num);
        write_register(blm_pkg::RegDivDen, den);
        write_register(blm_pkg::RegThreshold, thr);
        write_register(RegSpare, 16'($urandom));
        read_register(blm_pkg::RegDivNum);
        read_register(blm_pkg::RegDivDen);
        read_register(blm_pkg::RegThreshold);
        setting_total++;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls, calm stretches and one long hold-off.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        bit          rx_burst;
        rx_burst = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_due) begin
                m_axis_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
                long_hold_due = 1'b0;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 9);
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            if (sb.words_checked % 8 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned   k;
        int unsigned   p;
        int unsigned   den;
        int unsigned   num;
        logic [15:0]   thr;
        sb            = new();
        tx_burst      = 1'b0;
        long_hold_due = 1'b0;
        sample_total  = 0;
        window_total  = 0;
        setting_total = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: curve ends, absent windows and an alternating pattern.
        foreach (DirectedLevels[k]) begin
            tx_burst = ($urandom_range(0, 2) == 0);
            send_window(WinConst, DirectedLevels[k]);
        end
        send_window(WinAlternate, 0);

        // Long receiver hold-off while samples keep coming back to back.
        long_hold_due = 1'b1;
        for (k = 0; k < 3; k++) begin
            tx_burst = 1'b1;
            send_window(WinNoisy, $urandom_range(1650, 2100));
        end
        for (k = 0; k < 5; k++) send_random_window();

        // Zero threshold: always present, and zero readings pull the smoothed value down.
        configure(16'd1, 16'd1, 16'd0);
        send_window(WinConst, 0);
        send_window(WinConst, 0);
        for (k = 0; k < 4; k++) send_random_window();

        // Largest ratio and threshold: non-zero readings reach full scale.
        configure(16'd65535, 16'd1, 16'd65535);
        send_window(WinConst, 4095);
        send_window(WinConst, 0);
        send_window(WinConst, 1);
        for (k = 0; k < 2; k++) send_random_window();

        // Zero denominator.
        configure(16'd3, 16'd0, 16'd3000);
        for (k = 0; k < 3; k++) send_random_window();

        // Zero numerator against the largest denominator.
        configure(16'd0, 16'd65535, 16'd0);
        send_window(WinConst, 4095);
        send_random_window();

        // Unity ratio at full width, lowest non-zero threshold.
        configure(16'd65535, 16'd65535, 16'd1);
        send_window(WinConst, 0);
        send_window(WinConst, 4095);
        send_random_window();

        // Random settings, mostly near a two-to-one divider.
        for (p = 0; p < RandomPhases; p++) begin
            if ($urandom_range(0, 4) == 0) begin
                num = $urandom_range(0, 65535);
                den = $urandom_range(0, 65535);
                thr = 16'($urandom_range(0, 65535));
            end else begin
                den = $urandom_range(1, 4000);
                num = den * 2 + $urandom_range(0, den / 5) - den / 10;
                if (num > 65535) num = 65535;
                thr = 16'($urandom_range(2000, 4200));
            end
            configure(num[15:0], den[15:0], thr);
            for (k = 0; k < PhaseWindows; k++) send_random_window();
        end

        wait_idle();
        $display("Sent %0d samples in %0d windows under %0d register settings.",
                 sample_total, window_total, setting_total);
        $display("Checked %0d result words; %0d mismatches, %0d words missing.",
                 sb.words_checked, sb.mismatches, sb.expected_words.size());
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/blm_pkg.sv
hdl/battery_level_monitor.sv
sim/tb_battery_level_monitor.sv
